[hw/rtl/rcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_pkg: shared definitions of the raster cell classifier
// Field widths, register reset values, cell type codes and the records that
// travel between the classifier's modules.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;

  localparam int unsigned WIDTH_CFG_W  = 11;
  localparam int unsigned HEIGHT_CFG_W = 13;
  localparam int unsigned GAIN_W       = 8;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned POT_W        = 16;
  localparam int unsigned CHG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST     = 11'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST    = 13'd480;
  localparam logic [GAIN_W-1:0]       PGAIN_RST     = 8'd179;
  localparam logic [GAIN_W-1:0]       CGAIN_RST     = 8'd26;
  localparam logic [PIX_W-1:0]        GREEN_NEUTRAL = 8'd128;

  typedef enum logic [1:0] {
    CELL_VACUUM  = 2'd0,
    CELL_METAL   = 2'd1,
    CELL_BOUND   = 2'd2,
    CELL_MBORDER = 2'd3
  } cell_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_POTENTIAL_GAIN = 2'd2,
    CFG_CHARGE_GAIN    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic             conductive;
    cell_type_e       cell_type;
  } cell_t;

  typedef struct packed {
    logic has_above;
    logic promo_ok;
    logic last_row;
    logic last_col;
  } pos_flags_t;

  typedef struct packed {
    logic [GAIN_W-1:0] potential_gain;
    logic [GAIN_W-1:0] charge_gain;
  } gains_t;

  typedef struct packed {
    cell_type_e              cell_type;
    logic                    conductive;
    logic signed [POT_W-1:0] potential;
    logic [CHG_W-1:0]        charge;
    logic                    frame_end;
    logic                    run_last;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/raster_cell_classifier_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// raster_cell_classifier_top: raster map cell classifier
// Path: an accepted pixel is held in rcc_eval until the output buffer loads.
// Throughput: one pixel per cycle unless the output stalls; on the last row
// each pixel gives two results and the input is held back while they drain.
// Reset: counters and handshake state clear at once; the row stores are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module raster_cell_classifier_top import rcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [PIX_W-1:0]        red_i,
  input  wire logic [PIX_W-1:0]        green_i,
  input  wire logic [PIX_W-1:0]        blue_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   cell_type_o,
  output logic                         conductive_o,
  output logic signed [POT_W-1:0]      potential_o,
  output logic [CHG_W-1:0]             charge_o,
  output logic                         frame_end_o,
  output logic                         run_last_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [WIDTH_CFG_W-1:0]  width_q;
  logic [HEIGHT_CFG_W-1:0] height_q;
  gains_t                  gains_q;

  logic          in_acc, adv, s1_valid, can_load;
  logic [AW-1:0] rd_addr, wr_addr;
  cell_t         in_cell, wr_cell, held_x, held_x1;
  pos_flags_t    in_flags;
  cell_type_e    older_x, wr_older;
  logic          wr_older_en;
  result_t       res_a, res_b, res_out;
  logic [1:0]    res_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q                <= WIDTH_RST;
      height_q               <= HEIGHT_RST;
      gains_q.potential_gain <= PGAIN_RST;
      gains_q.charge_gain    <= CGAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:    width_q                <= cfg_data_i[WIDTH_CFG_W-1:0];
        CFG_IMAGE_HEIGHT:   height_q               <= cfg_data_i[HEIGHT_CFG_W-1:0];
        CFG_POTENTIAL_GAIN: gains_q.potential_gain <= cfg_data_i[GAIN_W-1:0];
        CFG_CHARGE_GAIN:    gains_q.charge_gain    <= cfg_data_i[GAIN_W-1:0];
        default:            width_q                <= width_q;
      endcase
    end
  end

  assign adv        = s1_valid && can_load;
  assign in_stall_o = s1_valid && !can_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  rcc_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .width_cfg_i  (width_q),
    .height_cfg_i (height_q),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .addr_o       (rd_addr),
    .cell_o       (in_cell),
    .flags_o      (in_flags)
  );

  rcc_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk_i         (clk_i),
    .rd_en_i       (in_acc),
    .rd_addr_i     (rd_addr),
    .wr_en_i       (adv),
    .wr_addr_i     (wr_addr),
    .wr_cell_i     (wr_cell),
    .wr_older_en_i (wr_older_en),
    .wr_older_i    (wr_older),
    .held_x_o      (held_x),
    .held_x1_o     (held_x1),
    .older_x_o     (older_x)
  );

  rcc_eval #(.MAX_WIDTH(MAX_WIDTH)) u_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_acc),
    .adv_i         (adv),
    .cell_i        (in_cell),
    .flags_i       (in_flags),
    .addr_i        (rd_addr),
    .held_x_i      (held_x),
    .held_x1_i     (held_x1),
    .older_x_i     (older_x),
    .gains_i       (gains_q),
    .valid_o       (s1_valid),
    .res_a_o       (res_a),
    .res_b_o       (res_b),
    .res_cnt_o     (res_cnt),
    .wr_addr_o     (wr_addr),
    .wr_cell_o     (wr_cell),
    .wr_older_en_o (wr_older_en),
    .wr_older_o    (wr_older)
  );

  rcc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .load_cnt_i  (res_cnt),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .can_load_o  (can_load)
  );

  assign cell_type_o  = res_out.cell_type;
  assign conductive_o = res_out.conductive;
  assign potential_o  = res_out.potential;
  assign charge_o     = res_out.charge;
  assign frame_end_o  = res_out.frame_end;
  assign run_last_o   = res_out.run_last;

endmodule
`default_nettype wire

[hw/rtl/rcc_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_scan: raster position tracking and pixel classification
// Keeps the column and row counters, clamps the configured frame size and
// classifies the incoming pixel against its position in the frame.
// ----------------------------------------------------------------------------
module rcc_scan import rcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH),
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CW = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic [WIDTH_CFG_W-1:0]  width_cfg_i,
  input  wire logic [HEIGHT_CFG_W-1:0] height_cfg_i,
  input  wire logic [PIX_W-1:0]        red_i,
  input  wire logic [PIX_W-1:0]        green_i,
  input  wire logic [PIX_W-1:0]        blue_i,
  output logic [AW-1:0]                addr_o,
  output cell_t                        cell_o,
  output pos_flags_t                   flags_o
);

  logic [AW-1:0]           col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [CW-1:0]           w_cfg, w_clamp, x_ext, x_inc;
  logic [HEIGHT_CFG_W-1:0] h_clamp, y_ext, y_inc;
  logic                    edge_cell;

  always_comb begin
    w_cfg = CW'(width_cfg_i);
    if (w_cfg < CW'(3)) begin
      w_clamp = CW'(3);
    end else if (w_cfg > CW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = w_cfg;
    end

    if (height_cfg_i < HEIGHT_CFG_W'(3)) begin
      h_clamp = HEIGHT_CFG_W'(3);
    end else if (height_cfg_i > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
      h_clamp = HEIGHT_CFG_W'(MAX_HEIGHT);
    end else begin
      h_clamp = height_cfg_i;
    end

    x_ext = (CW'(col_q) < w_clamp) ? CW'(col_q) : (w_clamp - CW'(1));
    y_ext = (HEIGHT_CFG_W'(row_q) < h_clamp) ? HEIGHT_CFG_W'(row_q)
                                               : (h_clamp - HEIGHT_CFG_W'(1));
    x_inc = x_ext + CW'(1);
    y_inc = y_ext + HEIGHT_CFG_W'(1);

    flags_o.last_col  = (x_inc == w_clamp);
    flags_o.last_row  = (y_inc == h_clamp);
    flags_o.has_above = (y_ext != '0);
    flags_o.promo_ok  = (x_ext != '0) && !flags_o.last_col &&
                        (y_ext >= HEIGHT_CFG_W'(2));
    edge_cell = (x_ext == '0) || flags_o.last_col || (y_ext == '0) || flags_o.last_row;

    cell_o.blue       = blue_i;
    cell_o.green      = green_i;
    cell_o.conductive = (red_i != '0) || (green_i != GREEN_NEUTRAL);
    if (edge_cell || (green_i != GREEN_NEUTRAL)) begin
      cell_o.cell_type = CELL_BOUND;
    end else if (red_i != '0) begin
      cell_o.cell_type = CELL_METAL;
    end else begin
      cell_o.cell_type = CELL_VACUUM;
    end

    addr_o = AW'(x_ext);

    if (x_inc >= w_clamp) begin
      col_d = '0;
      row_d = (y_inc >= h_clamp) ? '0 : ROW_W'(y_inc);
    end else begin
      col_d = AW'(x_inc);
      row_d = ROW_W'(y_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rcc_line_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_line_mem: row stores of the classifier
// Holds the cells of the previous row and the types of the row before it.
// Reads are registered; the previous-row store has two read addresses.
// ----------------------------------------------------------------------------
module rcc_line_mem import rcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire cell_t         wr_cell_i,
  input  wire logic          wr_older_en_i,
  input  wire cell_type_e    wr_older_i,
  output cell_t              held_x_o,
  output cell_t              held_x1_o,
  output cell_type_e         older_x_o
);

  cell_t         held_mem [MAX_WIDTH];
  cell_type_e    older_mem [MAX_WIDTH];
  logic [AW-1:0] rd_addr1;

  assign rd_addr1 = (rd_addr_i == AW'(MAX_WIDTH - 1)) ? '0 : (rd_addr_i + AW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      held_mem[wr_addr_i] <= wr_cell_i;
    end
    if (rd_en_i) begin
      held_x_o  <= held_mem[rd_addr_i];
      held_x1_o <= held_mem[rd_addr1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_older_en_i) begin
      older_mem[wr_addr_i] <= wr_older_i;
    end
    if (rd_en_i) begin
      older_x_o <= older_mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rcc_eval.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_eval: registered cell evaluation
// Holds one accepted pixel with its position flags, applies the metal border
// test to the cell above it and forms the potential and charge of results.
// ----------------------------------------------------------------------------
module rcc_eval import rcc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire logic          adv_i,
  input  wire cell_t         cell_i,
  input  wire pos_flags_t    flags_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire cell_t         held_x_i,
  input  wire cell_t         held_x1_i,
  input  wire cell_type_e    older_x_i,
  input  wire gains_t        gains_i,
  output logic               valid_o,
  output result_t            res_a_o,
  output result_t            res_b_o,
  output logic [1:0]         res_cnt_o,
  output logic [AW-1:0]      wr_addr_o,
  output cell_t              wr_cell_o,
  output logic               wr_older_en_o,
  output cell_type_e         wr_older_o
);

  logic          valid_q;
  cell_t         cell_q;
  pos_flags_t    flags_q;
  logic [AW-1:0] addr_q;
  cell_type_e    prev_ht_q;
  cell_type_e    ht, ot;

  logic signed [PIX_W:0]    gd_a, gd_b;
  logic signed [2*PIX_W+1:0] pr_a, pr_b;
  logic [CHG_W-1:0]         ch_a, ch_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cell_q  <= cell_i;
      flags_q <= flags_i;
      addr_q  <= addr_i;
    end
    if (adv_i) begin
      prev_ht_q <= ht;
    end
  end

  always_comb begin
    ht = held_x_i.cell_type;
    ot = ht;
    if ((ht == CELL_METAL) && flags_q.promo_ok &&
        ((prev_ht_q == CELL_VACUUM) || (held_x1_i.cell_type == CELL_VACUUM) ||
         (older_x_i == CELL_VACUUM) || (cell_q.cell_type == CELL_VACUUM))) begin
      ot = CELL_MBORDER;
    end
  end

  assign gd_a = $signed({1'b0, held_x_i.green}) - $signed({1'b0, GREEN_NEUTRAL});
  assign gd_b = $signed({1'b0, cell_q.green}) - $signed({1'b0, GREEN_NEUTRAL});
  assign pr_a = gd_a * $signed({1'b0, gains_i.potential_gain});
  assign pr_b = gd_b * $signed({1'b0, gains_i.potential_gain});
  assign ch_a = CHG_W'(held_x_i.blue) * CHG_W'(gains_i.charge_gain);
  assign ch_b = CHG_W'(cell_q.blue) * CHG_W'(gains_i.charge_gain);

  always_comb begin
    res_a_o.cell_type  = ot;
    res_a_o.conductive = held_x_i.conductive;
    res_a_o.potential  = pr_a[POT_W-1:0];
    res_a_o.charge     = ch_a;
    res_a_o.frame_end  = 1'b0;
    res_a_o.run_last   = !flags_q.last_row;

    res_b_o.cell_type  = cell_q.cell_type;
    res_b_o.conductive = cell_q.conductive;
    res_b_o.potential  = pr_b[POT_W-1:0];
    res_b_o.charge     = ch_b;
    res_b_o.frame_end  = flags_q.last_col;
    res_b_o.run_last   = 1'b1;
  end

  assign valid_o       = valid_q;
  assign res_cnt_o     = {1'b0, flags_q.has_above} + {1'b0, flags_q.last_row};
  assign wr_addr_o     = addr_q;
  assign wr_cell_o     = cell_q;
  assign wr_older_en_o = flags_q.has_above;
  assign wr_older_o    = ht;

endmodule
`default_nettype wire

[hw/rtl/rcc_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_out_buf: result output buffer
// Two result slots presented in order on the output channel. A new pair loads
// only when the buffer is empty or its last result drains in the same cycle.
// ----------------------------------------------------------------------------
module rcc_out_buf import rcc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire logic [1:0] load_cnt_i,
  input  wire result_t    res_a_i,
  input  wire result_t    res_b_i,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output result_t         res_o,
  output logic            can_load_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot_a_q, slot_b_q;
  logic       out_acc;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign res_o       = slot_a_q;

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = load_cnt_i;
    end else if (out_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_a_q <= res_a_i;
      slot_b_q <= res_b_i;
    end else if (out_acc) begin
      slot_a_q <= slot_b_q;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rcc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcc_checker: port-level checks of the raster cell classifier
// Watches the top-level ports and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module rcc_checker import rcc_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [1:0]            cell_type_o,
  input wire logic                  conductive_o,
  input wire logic signed [POT_W-1:0] potential_o,
  input wire logic [CHG_W-1:0]      charge_o,
  input wire logic                  frame_end_o,
  input wire logic                  run_last_o
);

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_type_o) &&
      $stable(conductive_o) && $stable(potential_o) && $stable(charge_o) &&
      $stable(frame_end_o) && $stable(run_last_o))
    else $error("stalled result changed");

  // The input side is only held back while a result waits on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // The upper cell of a last-row pair is followed at once by the lower cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o && !out_stall_i |=> out_valid_o)
    else $error("second result of a pair is missing");

  // The final cell of a frame sits on the frame edge and closes its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o && (cell_type_o == CELL_BOUND))
    else $error("frame end on a non-edge cell");

endmodule

bind raster_cell_classifier_top rcc_checker u_rcc_checker (.*);
`default_nettype wire
